// ===== src/xce_pkg.sv =====
// shared types and character constants for the xml character escaper
package xce_pkg;

  localparam int unsigned RunMax = 6;
  localparam int unsigned LenW   = 3;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChL     = 8'h6c;
  localparam logic [7:0] ChM     = 8'h6d;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChQ     = 8'h71;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] Ch3     = 8'h33;
  localparam logic [7:0] Ch9     = 8'h39;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [LenW-1:0]        len;
  } run_t;

endpackage

// ===== src/xce_if.sv =====
// handshake channel interfaces for input bytes, output runs and the mode register
interface xce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface xce_run_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface xce_cfg_if;
  logic valid;
  logic ready;
  logic attribute_mode;
  modport source (output valid, output attribute_mode, input ready);
  modport sink (input valid, input attribute_mode, output ready);
endinterface

// ===== src/xml_character_escaper.sv =====
// top level of the xml character escaper
//
// in_i takes one raw text byte per beat. out_o gives the escaped run for
// that byte, one to six beats, with last_of_run high on the final beat.
// cfg_i writes attribute_mode (0 element content, 1 attribute values); it
// is always ready. The user must write it only while no byte is in flight;
// the block itself does not enforce this. A taken byte passes the input
// register, then the run register, before its first output beat. Bytes
// that pass unchanged go at one input byte per cycle while the receiver is
// ready; an escaped byte holds the input until its run drains, a byte per beat.
// when the receiver stalls, the current beat holds and one more input byte
// waits in the input register before in_i.ready drops.
// reset clears both stages and sets attribute_mode to 0; no beats are
// pending afterwards.
module xml_character_escaper
  import xce_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  xce_byte_if.sink   in_i,
  xce_run_if.source  out_o,
  xce_cfg_if.sink    cfg_i
);

  logic       attr_q;
  logic       take;
  logic       byte_vld;
  logic [7:0] byte_val;
  run_t       run;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= 1'b0;
    end else if (cfg_i.valid) begin
      attr_q <= cfg_i.attribute_mode;
    end
  end

  xce_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .byte_i  (in_i.in_byte),
    .ready_o (in_i.ready),
    .take_i  (take),
    .valid_o (byte_vld),
    .byte_o  (byte_val)
  );

  xce_expand u_expand (
    .byte_i (byte_val),
    .attr_i (attr_q),
    .run_o  (run)
  );

  xce_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_vld),
    .run_i   (run),
    .take_o  (take),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .byte_o  (out_o.out_byte),
    .last_o  (out_o.last_of_run)
  );

endmodule

// ===== src/xce_in_reg.sv =====
// input register stage holding one raw byte
module xce_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  assign ready_o = !vld_q || take_i;
  assign vld_d   = valid_i ? 1'b1 : (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = vld_q;
  assign byte_o  = byte_q;

endmodule

// ===== src/xce_expand.sv =====
// maps one byte and the mode to its escaped run of bytes
module xce_expand
  import xce_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic       attr_i,
  output run_t       run_o
);

  logic [7:0] tens;
  logic [7:0] ones;

  always_comb begin
    priority if (byte_i >= 8'd30) begin
      tens = 8'd3;
    end else if (byte_i >= 8'd20) begin
      tens = 8'd2;
    end else if (byte_i >= 8'd10) begin
      tens = 8'd1;
    end else begin
      tens = 8'd0;
    end
    ones = byte_i - 8'((tens << 3) + (tens << 1));
  end

  always_comb begin
    run_o.bytes = {RunMax{byte_i}};
    run_o.len   = LenW'(1);
    priority if (byte_i == ChLt) begin
      run_o.bytes[0] = ChAmp; run_o.bytes[1] = ChL;
      run_o.bytes[2] = ChT;   run_o.bytes[3] = ChSemi;
      run_o.len = LenW'(4);
    end else if (byte_i == ChGt) begin
      run_o.bytes[0] = ChAmp; run_o.bytes[1] = ChG;
      run_o.bytes[2] = ChT;   run_o.bytes[3] = ChSemi;
      run_o.len = LenW'(4);
    end else if (byte_i == ChAmp) begin
      run_o.bytes[0] = ChAmp; run_o.bytes[1] = ChA;
      run_o.bytes[2] = ChM;   run_o.bytes[3] = ChP;
      run_o.bytes[4] = ChSemi;
      run_o.len = LenW'(5);
    end else if (attr_i && byte_i == ChQuot) begin
      run_o.bytes[0] = ChAmp; run_o.bytes[1] = ChQ;
      run_o.bytes[2] = ChU;   run_o.bytes[3] = ChO;
      run_o.bytes[4] = ChT;   run_o.bytes[5] = ChSemi;
      run_o.len = LenW'(6);
    end else if (attr_i && byte_i == ChApos) begin
      run_o.bytes[0] = ChAmp; run_o.bytes[1] = ChHash;
      run_o.bytes[2] = Ch3;   run_o.bytes[3] = Ch9;
      run_o.bytes[4] = ChSemi;
      run_o.len = LenW'(5);
    end else if (byte_i < ChSpace && (byte_i != ChLf || attr_i)) begin
      run_o.bytes[0] = ChAmp;
      run_o.bytes[1] = ChHash;
      if (tens != 8'd0) begin
        run_o.bytes[2] = ChZero + tens;
        run_o.bytes[3] = ChZero + ones;
        run_o.bytes[4] = ChSemi;
        run_o.len = LenW'(5);
      end else begin
        run_o.bytes[2] = ChZero + ones;
        run_o.bytes[3] = ChSemi;
        run_o.len = LenW'(4);
      end
    end else begin
      run_o.len = LenW'(1);
    end
  end

endmodule

// ===== src/xce_serializer.sv =====
// run register that hands out one escaped byte per output beat
module xce_serializer
  import xce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  run_t       run_i,
  output logic       take_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic            vld_q, vld_d;
  run_t            run_q;
  logic [LenW-1:0] idx_q, idx_d;
  logic            beat;

  assign beat   = vld_q && ready_i;
  assign last_o = (idx_q == run_q.len - LenW'(1));
  assign take_o = valid_i && (!vld_q || (beat && last_o));

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (take_o) begin
      vld_d = 1'b1;
      idx_d = '0;
    end else if (beat) begin
      if (last_o) begin
        vld_d = 1'b0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      run_q <= run_i;
    end
  end

  always_comb begin
    unique case (idx_q)
      3'd0:    byte_o = run_q.bytes[0];
      3'd1:    byte_o = run_q.bytes[1];
      3'd2:    byte_o = run_q.bytes[2];
      3'd3:    byte_o = run_q.bytes[3];
      3'd4:    byte_o = run_q.bytes[4];
      3'd5:    byte_o = run_q.bytes[5];
      default: byte_o = run_q.bytes[0];
    endcase
  end

  assign valid_o = vld_q;

endmodule

// ===== sim/xml_character_escaper_tb.sv =====
// testbench for the xml character escaper: directed and random byte streams checked against a run predictor
`timescale 1ns / 100ps

module xml_character_escaper_tb;
  import xce_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  xce_byte_if in_if ();
  xce_run_if  out_if ();
  xce_cfg_if  cfg_if ();

  xml_character_escaper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [7:0] text_bytes[$];
  beat_t      escaped_beats[$];
  beat_t      got_beat;
  logic       attr_mode;
  logic       idle_on;
  logic       hold_off;
  int         send_gap;
  int         recv_gap;
  int         bytes_taken;
  int         errors;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void predict_escape(input logic [7:0] b);
    logic [7:0] run [0:5];
    string      ent;
    beat_t      bt;
    int         n;
    ent = "";
    n   = 0;
    if (b == ChLt) ent = "&lt;";
    else if (b == ChGt) ent = "&gt;";
    else if (b == ChAmp) ent = "&amp;";
    else if (attr_mode && b == ChQuot) ent = "&quot;";
    else if (attr_mode && b == ChApos) ent = "&#39;";
    if (ent.len() > 0) begin
      for (int i = 0; i < ent.len(); i++) run[i] = ent[i];
      n = ent.len();
    end else if (b < ChSpace && (b != ChLf || attr_mode)) begin
      run[0] = ChAmp;
      run[1] = ChHash;
      n = 2;
      if (b >= 8'd10) begin
        run[n] = ChZero + b / 8'd10;
        n = n + 1;
      end
      run[n] = ChZero + b % 8'd10;
      run[n+1] = ChSemi;
      n = n + 2;
    end else begin
      run[0] = b;
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      bt.ch   = run[i];
      bt.last = (i == n - 1);
      escaped_beats.push_back(bt);
    end
  endfunction

  function automatic logic [7:0] random_text_byte();
    case ($urandom_range(0, 9))
      0: return ChLt;
      1: return ChGt;
      2: return ChAmp;
      3: return ChQuot;
      4: return ChApos;
      5: return ChLf;
      6, 7: return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random(input int count);
    for (int i = 0; i < count; i++) text_bytes.push_back(random_text_byte());
  endtask

  task automatic wait_drained();
    while (text_bytes.size() != 0 || in_if.valid || escaped_beats.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_if.valid          <= 1'b1;
    cfg_if.attribute_mode <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    attr_mode = m;
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_escape(in_if.in_byte);
        bytes_taken = bytes_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (text_bytes.size() > 0) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= text_bytes.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (escaped_beats.size() == 0) begin
          $display("%0t: beat with none expected, got byte %h last %b",
                   $time, out_if.out_byte, out_if.last_of_run);
          errors = errors + 1;
        end else begin
          got_beat = escaped_beats.pop_front();
          if (out_if.out_byte !== got_beat.ch) begin
            $display("%0t: out_byte expected %h got %h", $time, got_beat.ch, out_if.out_byte);
            errors = errors + 1;
          end
          if (out_if.last_of_run !== got_beat.last) begin
            $display("%0t: last_of_run expected %b got %b",
                     $time, got_beat.last, out_if.last_of_run);
            errors = errors + 1;
          end
        end
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 8);
      end
    end
  end

  // long receiver hold-off so the input stalls
  initial begin
    hold_off = 1'b0;
    while (bytes_taken < 150) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.in_byte         = 8'h00;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.attribute_mode = 1'b0;
    attr_mode             = 1'b0;
    idle_on               = 1'b1;
    send_gap              = 0;
    recv_gap              = 0;
    bytes_taken           = 0;
    errors                = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // element content
    write_mode(1'b0);
    text_bytes = '{8'h00, 8'h09, ChLf, 8'h1f, ChSpace, ChLt, ChGt, ChAmp, ChQuot, ChApos,
                   8'h41, 8'h7f, 8'h80, 8'hff, 8'h0d};
    wait_drained();

    // attribute values
    write_mode(1'b1);
    text_bytes = '{ChQuot, ChApos, ChLf, 8'h09, 8'h00, 8'h1f, ChLt, ChAmp, 8'hff, ChSpace};
    wait_drained();

    add_random(100);
    wait_drained();
    write_mode(1'b0);
    add_random(120);
    wait_drained();
    write_mode(1'b1);
    add_random(80);
    wait_drained();

    // full rate at the end
    write_mode(1'b0);
    idle_on <= 1'b0;
    add_random(80);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
